[hw/rtl/running_median_insert_delete_unit_macros.svh]
// Assertion macros for the running median unit checker.
`ifndef RUNNING_MEDIAN_INSERT_DELETE_UNIT_MACROS_SVH
`define RUNNING_MEDIAN_INSERT_DELETE_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RMID_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RMID_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/rmid_pkg.sv]
// Shared types and constants for the running median unit.
package rmid_pkg;

   localparam int REQ_VALUE_WIDTH  = 32;
   localparam int MEDIAN_WIDTH     = 33;
   localparam int COUNT_OUT_WIDTH  = 11;

   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef struct packed {
      logic insert_en;
      logic delete_en;
   } cell_ctl_type;

endpackage

[hw/rtl/rmid_cell.sv]
// One cell of the sorted chain: holds one value, shifts right on insert, left on delete.
module rmid_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  rmid_pkg::cell_ctl_type        ctl,
   input  logic                          in_range,
   input  logic signed [VALUE_WIDTH-1:0] x,
   input  logic signed [VALUE_WIDTH-1:0] left_value,
   input  logic                          left_le,
   input  logic signed [VALUE_WIDTH-1:0] right_value,
   output logic signed [VALUE_WIDTH-1:0] value,
   output logic                          le,
   output logic                          eq
);

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;

   assign value = value_ff;
   assign le    = in_range && (value_ff <= x);
   assign eq    = in_range && (value_ff == x);

   always_comb begin
      value_in = value_ff;
      if (ctl.insert_en) begin
         if (le) begin
            value_in = value_ff;
         end else if (left_le) begin
            value_in = x;
         end else begin
            value_in = left_value;
         end
      end else if (ctl.delete_en) begin
         if (in_range && (!le || eq)) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[hw/rtl/rmid_median_sel.sv]
// Median select: picks the middle cells of the chain and sums them.
module rmid_median_sel #(
   parameter int CAPACITY    = 1024,
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 11
) (
   input  logic signed [VALUE_WIDTH-1:0]            cell_value [CAPACITY],
   input  logic        [COUNT_WIDTH-1:0]            count,
   output logic signed [rmid_pkg::MEDIAN_WIDTH-1:0] doubled_median
);

   localparam int MW = rmid_pkg::MEDIAN_WIDTH;

   logic [COUNT_WIDTH-1:0]        hi_idx;
   logic [COUNT_WIDTH-1:0]        lo_idx;
   logic signed [VALUE_WIDTH-1:0] hi_value;
   logic signed [VALUE_WIDTH-1:0] lo_value;
   logic signed [63:0]            sum;

   assign hi_idx = count >> 1;
   assign lo_idx = count[0] ? hi_idx : hi_idx - COUNT_WIDTH'(1);

   always_comb begin
      hi_value = '0;
      lo_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hi_idx == COUNT_WIDTH'(i)) begin
            hi_value = hi_value | cell_value[i];
         end
         if (lo_idx == COUNT_WIDTH'(i)) begin
            lo_value = lo_value | cell_value[i];
         end
      end
   end

   assign sum            = 64'(lo_value) + 64'(hi_value);
   assign doubled_median = MW'(sum);

endmodule

[hw/rtl/running_median_insert_delete_unit.sv]
// Running median unit: sorted chain of cells with insert, delete and doubled median result.
//
// Each accepted beat (start high while busy low) adds or removes one copy of a value
// in an ascending store of CAPACITY cells. Busy is high in the cycle after the
// accept, while every cell compares the value and shifts toward its neighbor; in the
// next cycle the middle cells are selected and summed, and the result beat shows on
// the rsp_ ports, marked by rsp_strobe, in the cycle after that. A new beat can be
// accepted while the last one is in its median select cycle, but not in its cell
// update cycle. The receiver cannot stall: every result is taken when strobed.
// rsp_error flags a removal of an absent value, a removal that empties the store,
// or an add to a full store (dropped); rsp_doubled_median is then 0.
module running_median_insert_delete_unit #(
   parameter int CAPACITY    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   output logic                                          busy,
   input  logic                                          req_mode,
   input  logic signed [rmid_pkg::REQ_VALUE_WIDTH-1:0]   req_value,
   output logic                                          rsp_strobe,
   output logic                                          rsp_error,
   output logic signed [rmid_pkg::MEDIAN_WIDTH-1:0]      rsp_doubled_median,
   output logic        [rmid_pkg::COUNT_OUT_WIDTH-1:0]   rsp_element_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = rmid_pkg::MEDIAN_WIDTH;
   localparam int OW = rmid_pkg::COUNT_OUT_WIDTH;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_UPDATE = 2'd1;
   localparam logic [1:0] S_MEDIAN = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic                          err_ff, err_in;
   logic                          mode_ff;
   logic signed [VALUE_WIDTH-1:0] x_ff;
   logic                          accept;
   logic                          full;
   logic                          found;

   logic                          strobe_ff;
   logic                          rsp_error_ff;
   logic signed [MW-1:0]          rsp_median_ff;
   logic [OW-1:0]                 rsp_count_ff;

   rmid_pkg::cell_ctl_type        ctl;
   logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]           cell_le;
   logic [CAPACITY-1:0]           cell_eq;
   logic [CAPACITY-1:0]           in_range;
   logic signed [MW-1:0]          median;

   assign busy   = (state_ff == S_UPDATE);
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(CAPACITY));
   assign found  = |cell_eq;

   assign ctl.insert_en = busy && (mode_ff == rmid_pkg::MODE_ADD) && !full;
   assign ctl.delete_en = busy && (mode_ff == rmid_pkg::MODE_REMOVE) && found;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         assign in_range[gi] = (CW'(gi) < count_ff);
         rmid_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .in_range   (in_range[gi]),
            .x          (x_ff),
            .left_value ((gi == 0) ? x_ff : cell_value[(gi == 0) ? 0 : gi - 1]),
            .left_le    ((gi == 0) ? 1'b1 : cell_le[(gi == 0) ? 0 : gi - 1]),
            .right_value(cell_value[(gi == CAPACITY - 1) ? gi : gi + 1]),
            .value      (cell_value[gi]),
            .le         (cell_le[gi]),
            .eq         (cell_eq[gi])
         );
      end
   endgenerate

   rmid_median_sel #(
      .CAPACITY   (CAPACITY),
      .VALUE_WIDTH(VALUE_WIDTH),
      .COUNT_WIDTH(CW)
   ) u_median_sel (
      .cell_value    (cell_value),
      .count         (count_ff),
      .doubled_median(median)
   );

   always_comb begin
      state_in = S_IDLE;
      if (accept) begin
         state_in = S_UPDATE;
      end else if (state_ff == S_UPDATE) begin
         state_in = S_MEDIAN;
      end
   end

   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      if (busy) begin
         if (mode_ff == rmid_pkg::MODE_ADD) begin
            err_in = full;
            if (!full) begin
               count_in = count_ff + CW'(1);
            end
         end else begin
            err_in = !found || (count_ff == CW'(1));
            if (found) begin
               count_in = count_ff - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         err_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         err_ff    <= err_in;
         strobe_ff <= (state_ff == S_MEDIAN);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         x_ff    <= VALUE_WIDTH'(req_value);
      end
      if (state_ff == S_MEDIAN) begin
         rsp_error_ff  <= err_ff;
         rsp_median_ff <= err_ff ? '0 : median;
         rsp_count_ff  <= OW'(count_ff);
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_error          = rsp_error_ff;
   assign rsp_doubled_median = rsp_median_ff;
   assign rsp_element_count  = rsp_count_ff;

endmodule

[hw/rtl/rmid_checker.sv]
// Port-level checker for the running median unit, bound to the top level.
`include "running_median_insert_delete_unit_macros.svh"

module rmid_checker (
   input logic                                        clock,
   input logic                                        reset,
   input logic                                        start,
   input logic                                        busy,
   input logic                                        rsp_strobe,
   input logic                                        rsp_error,
   input logic signed [rmid_pkg::MEDIAN_WIDTH-1:0]    rsp_doubled_median,
   input logic        [rmid_pkg::COUNT_OUT_WIDTH-1:0] rsp_element_count
);

   `RMID_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
   `RMID_ASSERT(a_busy_result, busy |-> ##2 rsp_strobe, "no result beat two cycles after busy")
   `RMID_ASSERT(a_error_zero, (rsp_strobe && rsp_error) |-> (rsp_doubled_median == 0), "error beat with nonzero median")
   `RMID_ASSERT(a_ok_nonempty, (rsp_strobe && !rsp_error) |-> (rsp_element_count != 0), "good beat with empty store")

endmodule

bind running_median_insert_delete_unit rmid_checker u_rmid_checker (.*);
